### hdl/assert_macros.svh
// Assertion macros used by the scheduler top level.
// No dependencies; the macros expand to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on every rising edge outside reset.
`define RRTS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
// Check that a condition implies a consequence in the same cycle.
`define RRTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error("implication failed");
`else
`define RRTS_ASSERT(lbl, clk, rst_n, prop)
`define RRTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hdl/rrts_pkg.sv
// Shared types and constants of the round-robin task scheduler.
// No dependencies; imported by every scheduler module.
package rrts_pkg;

	localparam int RRTS_MAX_TASKS   = 8;
	localparam int RRTS_DELAY_WIDTH = 16;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELAY  = 2'd1,
		OP_EXIT   = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	localparam logic [1:0] ST_READY    = 2'd0;
	localparam logic [1:0] ST_BLOCKED  = 2'd1;
	localparam logic [1:0] ST_FINISHED = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_TICK,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t         opcode;
		logic [15:0] delay_ticks;
	} op_beat_t;

	typedef struct packed {
		logic [2:0]  running_slot;
		logic [2:0]  assigned_slot;
		logic        insert_ok;
		logic [31:0] elapsed_ticks;
	} res_beat_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic accept;
		logic insert;
		logic block;
		logic finish;
		logic tick;
		logic walk;
		logic scan_init;
		logic scan;
		logic load;
	} ctl_t;

	// Datapath to controller status.
	typedef struct packed {
		logic count_zero;
		logic walk_done;
		logic scan_found;
	} sts_t;

endpackage

### hdl/round_robin_task_scheduler.sv
// Round-robin task scheduler: top level with the result register.
// Depends on rrts_pkg, rrts_ctrl, rrts_dp and assert_macros.svh.
//
// Each operation beat (insert, delay, exit, tick) yields exactly one result
// beat carrying the running slot, the slot given by an insert with its success
// flag, and the wrapping tick count. One operation is in work at a time.
// Delay, exit and tick take longer than insert when they change the schedule,
// since each slot memory has a single read port: a tick walks every countdown
// one slot a cycle, then the next-task scan walks the status ring one slot a
// cycle, stopping at the first ready slot other than the idle slot or on
// coming back round to the running slot. A new operation is taken the cycle
// after the previous result is loaded, even while that result is still
// stalled in the output register.
`include "assert_macros.svh"

module round_robin_task_scheduler import rrts_pkg::*; #(
	parameter int MAX_TASKS   = RRTS_MAX_TASKS,
	parameter int DELAY_WIDTH = RRTS_DELAY_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      op_valid,
	output logic      op_stall,
	input  op_beat_t  op_beat,
	output logic      res_valid,
	input  logic      res_stall,
	output res_beat_t res_beat
);

	ctl_t      ctl;
	sts_t      sts;
	res_beat_t res_d;
	logic      res_free;
	logic      res_valid_q;
	res_beat_t res_beat_q;

	// The result register is free when empty or being drained this cycle.
	assign res_free = !res_valid_q || !res_stall;

	rrts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_beat  (op_beat),
		.sts      (sts),
		.res_free (res_free),
		.op_stall (op_stall),
		.ctl      (ctl)
	);

	rrts_dp #(
		.MAX_TASKS   (MAX_TASKS),
		.DELAY_WIDTH (DELAY_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.op_beat (op_beat),
		.ctl     (ctl),
		.sts     (sts),
		.res     (res_d)
	);

	// Hold the result beat until taken; load a new one only into a free slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			res_beat_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res_beat  = res_beat_q;

	// An accepted beat keeps the block busy in the following cycle.
	`RRTS_ASSERT(a_busy_after_accept, clk, arst_n, op_valid && !op_stall |=> op_stall)
	// Never overwrite a result beat that is still stalled.
	`RRTS_ASSERT_IMPL(a_no_overwrite, clk, arst_n, ctl.load, !res_valid_q || !res_stall)
	// A successful insert leaves a nonempty table behind.
	`RRTS_ASSERT_IMPL(a_insert_fills, clk, arst_n, res_valid && res_beat.insert_ok, !sts.count_zero)
	// With no tasks, the idle slot is reported as running.
	`RRTS_ASSERT_IMPL(a_empty_idle, clk, arst_n, res_valid && sts.count_zero, res_beat.running_slot == 3'd0)

endmodule

### hdl/rrts_ctrl.sv
// Sequencing state machine of the round-robin task scheduler.
// Depends on rrts_pkg; drives the command struct of rrts_dp.
module rrts_ctrl import rrts_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     op_valid,
	input  op_beat_t op_beat,
	input  sts_t     sts,
	input  logic     res_free,
	output logic     op_stall,
	output ctl_t     ctl
);

	state_t state_q;
	state_t state_nxt;
	logic   dly_nz;

	assign dly_nz = op_beat.delay_ticks != 16'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		op_stall  = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				op_stall = 1'b0;
				if (op_valid) begin
					ctl.accept = 1'b1;
					state_nxt  = S_DONE;
					unique case (op_beat.opcode)
						OP_INSERT: begin
							ctl.insert = 1'b1;
						end
						OP_DELAY: begin
							if (dly_nz && !sts.count_zero) begin
								ctl.block     = 1'b1;
								ctl.scan_init = 1'b1;
								state_nxt     = S_SCAN;
							end
						end
						OP_EXIT: begin
							if (!sts.count_zero) begin
								ctl.finish    = 1'b1;
								ctl.scan_init = 1'b1;
								state_nxt     = S_SCAN;
							end
						end
						OP_TICK: begin
							ctl.tick = 1'b1;
							if (!sts.count_zero) begin
								state_nxt = S_TICK;
							end
						end
					endcase
				end
			end
			S_TICK: begin
				ctl.walk = 1'b1;
				if (sts.walk_done) begin
					ctl.scan_init = 1'b1;
					state_nxt     = S_SCAN;
				end
			end
			S_SCAN: begin
				ctl.scan = 1'b1;
				if (sts.scan_found) begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (res_free) begin
					ctl.load  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
		endcase
	end

endmodule

### hdl/rrts_dp.sv
// Datapath of the round-robin task scheduler: slot memories, countdown walk,
// ring scan and counters. Depends on rrts_pkg; commanded by rrts_ctrl.
module rrts_dp import rrts_pkg::*; #(
	parameter int MAX_TASKS   = RRTS_MAX_TASKS,
	parameter int DELAY_WIDTH = RRTS_DELAY_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  op_beat_t  op_beat,
	input  ctl_t      ctl,
	output sts_t      sts,
	output res_beat_t res
);

	localparam int SW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_TASKS);
	localparam logic [32:0] DMAX = (33'd1 << DELAY_WIDTH) - 33'd1;

	function automatic logic [SW-1:0] ring_next(input logic [SW-1:0] x,
	                                             input logic [CW-1:0] n);
		logic [CW:0] x1;
		x1 = (CW+1)'(x) + (CW+1)'(1);
		return (x1 == (CW+1)'(n)) ? '0 : x1[SW-1:0];
	endfunction

	function automatic logic [2:0] slot3(input logic [SW-1:0] s);
		logic [SW+2:0] w;
		w = {3'b000, s};
		return w[2:0];
	endfunction

	logic [1:0]             st_mem [MAX_TASKS];
	logic [DELAY_WIDTH-1:0] cd_mem [MAX_TASKS];

	logic [CW-1:0]          count_q;
	logic [SW-1:0]          cur_q;
	logic [31:0]            tick_total_q;
	logic [SW-1:0]          assigned_q;
	logic                   ok_q;

	logic [CW-1:0]          walk_idx_q;
	logic                   walk_v_s1;
	logic [SW-1:0]          walk_idx_s1;
	logic [DELAY_WIDTH-1:0] cd_rd_s1;

	logic [SW-1:0]          scan_q;
	logic                   scan_v_s1;
	logic [SW-1:0]          scan_idx_s1;
	logic [1:0]             st_rd_s1;

	logic                   ins_ok;
	logic                   walk_issue;
	logic                   hit_cur;
	logic                   rdy;
	logic                   found;
	logic [32:0]            dly_wide;
	logic [DELAY_WIDTH-1:0] dly_sat;

	logic                   st_we;
	logic [SW-1:0]          st_wa;
	logic [1:0]             st_wd;
	logic                   cd_we;
	logic [SW-1:0]          cd_wa;
	logic [DELAY_WIDTH-1:0] cd_wd;

	assign ins_ok     = count_q != FULL;
	assign walk_issue = ctl.walk && (walk_idx_q != count_q);
	assign dly_wide   = 33'(op_beat.delay_ticks);
	assign dly_sat    = (dly_wide > DMAX) ? DMAX[DELAY_WIDTH-1:0] : dly_wide[DELAY_WIDTH-1:0];

	assign hit_cur = scan_idx_s1 == cur_q;
	assign rdy     = st_rd_s1 == ST_READY;
	assign found   = ctl.scan && scan_v_s1 && (hit_cur || (rdy && scan_idx_s1 != '0));

	assign sts.count_zero = count_q == '0;
	assign sts.walk_done  = !walk_v_s1 && (walk_idx_q == count_q);
	assign sts.scan_found = found;

	assign res.running_slot  = slot3(cur_q);
	assign res.assigned_slot = slot3(assigned_q);
	assign res.insert_ok     = ok_q;
	assign res.elapsed_ticks = tick_total_q;

	// Write port selection; the sources never overlap in time.
	always_comb begin
		st_we = 1'b0;
		st_wa = cur_q;
		st_wd = ST_READY;
		cd_we = 1'b0;
		cd_wa = cur_q;
		cd_wd = '0;
		priority if (ctl.insert && ins_ok) begin
			st_we = 1'b1;
			st_wa = count_q[SW-1:0];
			cd_we = 1'b1;
			cd_wa = count_q[SW-1:0];
		end else if (ctl.block) begin
			st_we = 1'b1;
			st_wd = ST_BLOCKED;
			cd_we = 1'b1;
			cd_wd = dly_sat;
		end else if (ctl.finish) begin
			st_we = 1'b1;
			st_wd = ST_FINISHED;
		end else if (walk_v_s1 && cd_rd_s1 != '0) begin
			cd_we = 1'b1;
			cd_wa = walk_idx_s1;
			cd_wd = cd_rd_s1 - DELAY_WIDTH'(1);
			st_wa = walk_idx_s1;
			st_we = cd_rd_s1 == DELAY_WIDTH'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[st_wa] <= st_wd;
		end
		if (cd_we) begin
			cd_mem[cd_wa] <= cd_wd;
		end
		st_rd_s1    <= st_mem[scan_q];
		cd_rd_s1    <= cd_mem[walk_idx_q[SW-1:0]];
		walk_idx_s1 <= walk_idx_q[SW-1:0];
		scan_idx_s1 <= scan_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			cur_q        <= '0;
			tick_total_q <= '0;
			assigned_q   <= '0;
			ok_q         <= 1'b0;
			walk_idx_q   <= '0;
			walk_v_s1    <= 1'b0;
			scan_q       <= '0;
			scan_v_s1    <= 1'b0;
		end else begin
			if (ctl.accept) begin
				ok_q       <= ctl.insert && ins_ok;
				assigned_q <= (ctl.insert && ins_ok) ? count_q[SW-1:0] : '0;
			end
			if (ctl.insert && ins_ok) begin
				count_q <= count_q + CW'(1);
			end
			if (ctl.tick) begin
				tick_total_q <= tick_total_q + 32'd1;
				walk_idx_q   <= '0;
			end else if (walk_issue) begin
				walk_idx_q <= walk_idx_q + CW'(1);
			end
			walk_v_s1 <= walk_issue;
			if (ctl.scan_init) begin
				scan_q    <= ring_next(cur_q, count_q);
				scan_v_s1 <= 1'b0;
			end else if (ctl.scan) begin
				scan_q    <= ring_next(scan_q, count_q);
				scan_v_s1 <= 1'b1;
			end else begin
				scan_v_s1 <= 1'b0;
			end
			if (found) begin
				cur_q <= hit_cur ? (rdy ? cur_q : '0) : scan_idx_s1;
			end
		end
	end

endmodule

### verif/round_robin_task_scheduler_test.sv
// Self-checking testbench for the round-robin task scheduler.
// Depends on rrts_pkg and round_robin_task_scheduler; a cycle-free predictor
// produces the result of every operation beat and each result beat is compared.
`timescale 1ns / 1ps

module round_robin_task_scheduler_test;
	import rrts_pkg::*;

	localparam int SLOTS = RRTS_MAX_TASKS;

	logic      clk;
	logic      arst_n;
	logic      op_valid;
	logic      op_stall;
	op_beat_t  op_beat;
	logic      res_valid;
	logic      res_stall;
	res_beat_t res_beat;

	round_robin_task_scheduler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_stall  (op_stall),
		.op_beat   (op_beat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_beat  (res_beat)
	);

	// Predicted scheduler state: task table, running slot and tick counter.
	int unsigned   task_total;
	logic [1:0]    slot_state [SLOTS];
	logic [15:0]   slot_timer [SLOTS];
	int unsigned   run_slot;
	logic [31:0]   tick_seen;

	// Result beats predicted for accepted operations, oldest first.
	res_beat_t     pending_results [$];
	int            mismatch_count;

	// Idling controls for both channels, and the long receiver hold-off.
	bit            op_idle_en;
	bit            res_idle_en;
	int            stall_left;
	int            hold_left;

	// Free-running clock, 2 ns period.
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Pick the next running slot: walk the ring of inserted slots after the
	// running one, take the first ready slot other than the idle slot. Coming
	// back around, keep the running slot if it is ready, else fall back to idle.
	function automatic int unsigned next_running_slot();
		int unsigned s;
		int unsigned i;
		if (task_total == 0 || run_slot >= task_total)
			return 0;
		s = (run_slot + 1) % task_total;
		for (i = 0; i < task_total; i++) begin
			if (s == run_slot)
				return (slot_state[s] == ST_READY) ? run_slot : 0;
			if (slot_state[s] == ST_READY && s != 0)
				return s;
			s = (s + 1) % task_total;
		end
		return 0;
	endfunction

	// Apply one operation to the predicted state and return its result beat.
	function automatic res_beat_t schedule_op(op_beat_t b);
		res_beat_t   r;
		int unsigned i;
		r = '0;
		case (b.opcode)
			OP_INSERT: begin
				// Table full leaves everything alone and answers not-ok.
				if (task_total < SLOTS) begin
					r.assigned_slot = 3'(task_total);
					r.insert_ok = 1'b1;
					slot_state[task_total] = ST_READY;
					slot_timer[task_total] = '0;
					if (task_total == 0)
						run_slot = 0;
					task_total++;
				end
			end
			OP_DELAY: begin
				// Zero delay and empty table are no-ops. The delay field is as
				// wide as the countdown, so it never needs to saturate here.
				if (b.delay_ticks != '0 && task_total != 0 && run_slot < task_total) begin
					slot_timer[run_slot] = b.delay_ticks;
					slot_state[run_slot] = ST_BLOCKED;
					run_slot = next_running_slot();
				end
			end
			OP_EXIT: begin
				if (task_total != 0 && run_slot < task_total) begin
					slot_state[run_slot] = ST_FINISHED;
					run_slot = next_running_slot();
				end
			end
			default: begin
				// Tick: count down every live timer; one reaching zero readies its
				// slot, even a finished one.
				if (task_total != 0) begin
					for (i = 0; i < task_total; i++) begin
						if (slot_timer[i] != '0) begin
							slot_timer[i] = slot_timer[i] - 16'd1;
							if (slot_timer[i] == '0)
								slot_state[i] = ST_READY;
						end
					end
					run_slot = next_running_slot();
				end
				tick_seen = tick_seen + 32'd1;
			end
		endcase
		r.running_slot = 3'(run_slot);
		r.elapsed_ticks = tick_seen;
		return r;
	endfunction

	// Print one mismatch line and count it.
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s mismatch: got %0d, want %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// Offer one operation beat, optionally after a random idle burst, and hold
	// it until accepted. Valid stays high on return so back-to-back beats flow.
	task automatic send_op(input op_beat_t b);
		if (op_idle_en && $urandom_range(0, 3) == 0) begin
			op_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		op_valid <= 1'b1;
		op_beat <= b;
		do
			@(posedge clk);
		while (op_stall);
		pending_results.push_back(schedule_op(b));
	endtask

	function automatic op_beat_t make_op(op_t code, logic [15:0] ticks);
		op_beat_t b;
		b.opcode = code;
		b.delay_ticks = ticks;
		return b;
	endfunction

	// Wait for every predicted result, then let the block settle.
	task automatic wait_results_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	// Result channel back-pressure: a long hold-off when requested, otherwise
	// random stall bursts while idling is enabled. One assignment per edge.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else if (res_idle_en && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 8) - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// Compare each accepted result beat field by field with the oldest prediction.
	always @(posedge clk) begin
		res_beat_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result running_slot",
						32'(res_beat.running_slot), 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (res_beat.running_slot !== want.running_slot)
					report_mismatch("running_slot", 32'(res_beat.running_slot),
							32'(want.running_slot));
				if (res_beat.assigned_slot !== want.assigned_slot)
					report_mismatch("assigned_slot", 32'(res_beat.assigned_slot),
							32'(want.assigned_slot));
				if (res_beat.insert_ok !== want.insert_ok)
					report_mismatch("insert_ok", 32'(res_beat.insert_ok),
							32'(want.insert_ok));
				if (res_beat.elapsed_ticks !== want.elapsed_ticks)
					report_mismatch("elapsed_ticks", res_beat.elapsed_ticks,
							want.elapsed_ticks);
			end
		end
	end

	// Operations on an empty table: delay and exit do nothing, tick only counts.
	task automatic test_empty_table();
		send_op(make_op(OP_TICK, 16'h0000));
		send_op(make_op(OP_DELAY, 16'd5));
		send_op(make_op(OP_EXIT, 16'hFFFF));
		send_op(make_op(OP_DELAY, 16'h0000));
	endtask

	// Fill all slots (the first becomes the running idle task), then overflow.
	task automatic test_fill_table();
		repeat (SLOTS) send_op(make_op(OP_INSERT, 16'h0000));
		send_op(make_op(OP_INSERT, 16'hFFFF));
	endtask

	// Zero delay, largest delay, shortest delay, exits, ticks reviving slots,
	// and enough blocking to push the schedule back onto the idle slot.
	task automatic test_directed_ops();
		send_op(make_op(OP_DELAY, 16'h0000));
		send_op(make_op(OP_DELAY, 16'hFFFF));
		send_op(make_op(OP_DELAY, 16'd1));
		send_op(make_op(OP_EXIT, 16'h0000));
		send_op(make_op(OP_TICK, 16'hFFFF));
		send_op(make_op(OP_TICK, 16'h0000));
		send_op(make_op(OP_DELAY, 16'd3));
		send_op(make_op(OP_DELAY, 16'd3));
		send_op(make_op(OP_EXIT, 16'h0000));
		send_op(make_op(OP_TICK, 16'h0000));
		send_op(make_op(OP_TICK, 16'h0000));
		send_op(make_op(OP_TICK, 16'h0000));
	endtask

	// Random operation: mostly ticks and short delays so slots keep cycling
	// between blocked and ready; exits and huge delays are rare since they
	// retire slots for the rest of the run. Ignored delay fields stay random.
	function automatic op_beat_t random_op();
		int unsigned pick;
		op_beat_t    b;
		pick = $urandom_range(0, 99);
		b.delay_ticks = 16'($urandom_range(0, 65535));
		if (pick < 4) begin
			b.opcode = OP_INSERT;
		end else if (pick < 6) begin
			b.opcode = OP_EXIT;
		end else if (pick < 45) begin
			b.opcode = OP_DELAY;
			pick = $urandom_range(0, 99);
			if (pick < 75)
				b.delay_ticks = 16'($urandom_range(0, 6));
			else if (pick < 98)
				b.delay_ticks = 16'($urandom_range(7, 40));
		end else begin
			b.opcode = OP_TICK;
		end
		return b;
	endfunction

	task automatic test_random_ops(input int count);
		repeat (count) send_op(random_op());
	endtask

	// Hold the result channel off long enough that the block fills and stalls
	// its input while beats keep being offered.
	task automatic test_backpressure();
		hold_left = 300;
		repeat (30) send_op(random_op());
	endtask

	initial begin
		arst_n = 1'b0;
		op_valid = 1'b0;
		op_beat = '0;
		res_stall = 1'b0;
		task_total = 0;
		run_slot = 0;
		tick_seen = '0;
		mismatch_count = 0;
		stall_left = 0;
		hold_left = 0;
		op_idle_en = 1'b0;
		res_idle_en = 1'b0;
		foreach (slot_state[i]) begin
			slot_state[i] = ST_READY;
			slot_timer[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats run with idling on both sides.
		op_idle_en = 1'b1;
		res_idle_en = 1'b1;
		test_empty_table();
		test_fill_table();
		test_directed_ops();
		op_valid <= 1'b0;
		wait_results_drained();

		test_backpressure();
		op_valid <= 1'b0;
		wait_results_drained();

		test_random_ops(1350);
		op_valid <= 1'b0;
		wait_results_drained();

		// Last stretch at full rate: no gaps, no stalls.
		op_idle_en = 1'b0;
		res_idle_en = 1'b0;
		test_random_ops(300);
		op_valid <= 1'b0;
		wait_results_drained();

		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
